// ===== rtl/swm_pkg.sv =====
// Shared types and constants for the sliding window median filter.
// No dependencies; imported by swm_cell and sliding_window_median.
`default_nettype none

package swm_pkg;

  // Width of the window length configuration input.
  localparam int unsigned CFG_W = 7;

  // Move flags that one cell hands to its neighbors.
  typedef struct packed {
    logic to_left;
    logic to_right;
  } swm_move_t;

  // Per-cell status seen by the top level.
  typedef struct packed {
    logic is_del;
    logic is_rank;
  } swm_stat_t;

endpackage

`default_nettype wire

// ===== rtl/swm_cell.sv =====
// One cell of the sorted window: holds one sample and its age.
// Depends on swm_pkg for the move and status structs.
`default_nettype none

module swm_cell #(
  parameter int unsigned SAMPLE_BITS = 32,
  parameter int unsigned AGE_W       = 6,
  parameter int unsigned CNT_W       = 7,
  parameter int unsigned IDX         = 0
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          full_i,
  input  logic [CNT_W-1:0]              fill_i,
  input  logic [AGE_W-1:0]              old_age_i,
  input  logic [AGE_W-1:0]              rank_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] old_val_i,
  input  swm_pkg::swm_move_t            left_move_i,
  input  logic [SAMPLE_BITS-1:0]        left_val_i,
  input  logic [AGE_W-1:0]              left_age_i,
  input  swm_pkg::swm_move_t            right_move_i,
  input  logic [SAMPLE_BITS-1:0]        right_val_i,
  input  logic [AGE_W-1:0]              right_age_i,
  output swm_pkg::swm_move_t            move_o,
  output logic [SAMPLE_BITS-1:0]        val_o,
  output logic [AGE_W-1:0]              age_o,
  output swm_pkg::swm_stat_t            stat_o,
  output logic [SAMPLE_BITS-1:0]        del_val_o,
  output logic [SAMPLE_BITS-1:0]        rank_val_o
);
  import swm_pkg::*;

  logic signed [SAMPLE_BITS-1:0] val_q, val_d;
  logic [AGE_W-1:0]              age_q, age_d;
  logic                          occ, is_del, keep, gt_new, right_of_del, stay;

  always_comb begin
    occ          = CNT_W'(IDX) < fill_i;
    is_del       = full_i && occ && (age_q == old_age_i);
    keep         = occ && !is_del;
    gt_new       = val_q > sample_i;
    // Equal values left of the oldest entry would be older still, so >= suffices.
    right_of_del = full_i && (val_q >= old_val_i);
    stay         = keep && (right_of_del == gt_new);
  end

  assign move_o.to_left  = keep && right_of_del && !gt_new;
  assign move_o.to_right = keep && gt_new && !right_of_del;

  always_comb begin
    if (right_move_i.to_left) begin
      val_d = right_val_i;
      age_d = right_age_i + AGE_W'(1);
    end else if (left_move_i.to_right) begin
      val_d = left_val_i;
      age_d = left_age_i + AGE_W'(1);
    end else if (stay) begin
      val_d = val_q;
      age_d = age_q + AGE_W'(1);
    end else begin
      // The one free slot in the live range takes the new sample.
      val_d = sample_i;
      age_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o          = val_q;
  assign age_o          = age_q;
  assign stat_o.is_del  = is_del;
  assign stat_o.is_rank = (AGE_W'(IDX) == rank_i);
  assign del_val_o      = is_del ? val_q : '0;
  assign rank_val_o     = stat_o.is_rank ? val_q : '0;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_median.sv =====
// Sliding window lower median filter: top level with the cell chain and result queue.
// Depends on swm_pkg and swm_cell.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------------
//   in      | input     | in_valid_i / in_ready_o    | sample_i (signed)
//   out     | output    | out_valid_o / out_ready_i  | median_value_o (signed)
//   cfg     | input     | cfg_valid_i / cfg_ready_o  | window_len_i
//
// One sample per cycle while in_ready_o is high: the whole cell row updates in
// the cycle a transaction is accepted. Results come only once the window is full;
// the median cell is written into the result queue in the cycle after acceptance
// and is valid on the output once queued. Reset clears the fill count and the
// queue and sets the window length to 3 (or WINDOW_MAX if smaller); the cell
// contents are left as they are. A stalled output holds up to three results; the
// input stalls when the queue is full, or holds two with a result pending.
`default_nettype none

module sliding_window_median #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] median_value_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [swm_pkg::CFG_W-1:0]     window_len_i
);
  import swm_pkg::*;

  localparam int unsigned CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int unsigned AGE_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned RST_W      = (WINDOW_MAX < 3) ? WINDOW_MAX : 3;
  localparam int unsigned FIFO_DEPTH = 3;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // Window settings, decoded once at configuration time.
  logic [CNT_W-1:0] win_q, win_d;
  logic [AGE_W-1:0] old_age_q, old_age_d;   // age of the oldest entry, window - 1
  logic [AGE_W-1:0] rank_q, rank_d;         // lower median rank
  logic [CNT_W-1:0] fill_q, fill_d, new_fill;
  logic             pend_q, pend_d;         // cell row holds a result not yet queued
  logic [31:0]      w_sel;

  logic cfg_we, accept, full;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign accept      = in_valid_i && in_ready_o;

  // Clamp the written length: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (window_len_i == '0) begin
      w_sel = 32'd1;
    end else if (32'(window_len_i) > 32'(WINDOW_MAX)) begin
      w_sel = 32'(WINDOW_MAX);
    end else begin
      w_sel = 32'(window_len_i);
    end
    win_d     = CNT_W'(w_sel);
    old_age_d = AGE_W'(w_sel - 32'd1);
    rank_d    = AGE_W'((w_sel - 32'd1) >> 1);
  end

  assign full     = (fill_q == win_q);
  assign new_fill = full ? fill_q : fill_q + CNT_W'(1);

  always_comb begin
    fill_d = fill_q;
    if (cfg_we) begin
      fill_d = '0;                      // drop the window on a length change
    end else if (accept) begin
      fill_d = new_fill;
    end
  end

  assign pend_d = accept && (new_fill == win_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= CNT_W'(RST_W);
      old_age_q <= AGE_W'(RST_W - 1);
      rank_q    <= AGE_W'((RST_W - 1) / 2);
      fill_q    <= '0;
      pend_q    <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_q     <= win_d;
        old_age_q <= old_age_d;
        rank_q    <= rank_d;
      end
      fill_q <= fill_d;
      pend_q <= pend_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row. Cell 0 holds the smallest value. On each accepted sample the
  // oldest entry drops out (when full), entries shift one place toward the gap,
  // and the new sample lands in the one slot no neighbor fills.
  // ---------------------------------------------------------------------------
  swm_move_t               cell_move    [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0]  cell_val     [WINDOW_MAX];
  logic [AGE_W-1:0]        cell_age     [WINDOW_MAX];
  swm_stat_t               cell_stat    [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0]  cell_del_val [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0]  cell_rnk_val [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]   del_vec, rank_vec;
  logic [SAMPLE_BITS-1:0]  old_val, rank_val;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_move_t              l_move, r_move;
    logic [SAMPLE_BITS-1:0] l_val, r_val;
    logic [AGE_W-1:0]       l_age, r_age;

    if (i == 0) begin : g_lo
      assign l_move = '0;
      assign l_val  = '0;
      assign l_age  = '0;
    end else begin : g_lo
      assign l_move = cell_move[i-1];
      assign l_val  = cell_val[i-1];
      assign l_age  = cell_age[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_hi
      assign r_move = '0;
      assign r_val  = '0;
      assign r_age  = '0;
    end else begin : g_hi
      assign r_move = cell_move[i+1];
      assign r_val  = cell_val[i+1];
      assign r_age  = cell_age[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .AGE_W      (AGE_W),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk_i       (clk_i),
      .en_i        (accept),
      .full_i      (full),
      .fill_i      (fill_q),
      .old_age_i   (old_age_q),
      .rank_i      (rank_q),
      .sample_i    (sample_i),
      .old_val_i   (old_val),
      .left_move_i (l_move),
      .left_val_i  (l_val),
      .left_age_i  (l_age),
      .right_move_i(r_move),
      .right_val_i (r_val),
      .right_age_i (r_age),
      .move_o      (cell_move[i]),
      .val_o       (cell_val[i]),
      .age_o       (cell_age[i]),
      .stat_o      (cell_stat[i]),
      .del_val_o   (cell_del_val[i]),
      .rank_val_o  (cell_rnk_val[i])
    );

    assign del_vec[i]  = cell_stat[i].is_del;
    assign rank_vec[i] = cell_stat[i].is_rank;
  end

  // Broadcast the oldest value and gather the median; each is one-hot masked.
  always_comb begin
    old_val  = '0;
    rank_val = '0;
    for (int unsigned i = 0; i < WINDOW_MAX; i++) begin
      old_val  = old_val  | cell_del_val[i];
      rank_val = rank_val | cell_rnk_val[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue. Push the median the cycle after its sample; the input
  // holds off when the queue is full, or is one short of full with a result pending.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [FCNT_W-1:0]      fcnt_q;
  logic                   push, pop;

  assign push           = pend_q;
  assign out_valid_o    = (fcnt_q != '0);
  assign pop            = out_valid_o && out_ready_i;
  assign median_value_o = fifo_q[rd_ptr_q];
  assign in_ready_o     = !((fcnt_q == FCNT_W'(FIFO_DEPTH)) ||
                            ((fcnt_q == FCNT_W'(FIFO_DEPTH - 1)) && pend_q));

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= rank_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fcnt_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        fcnt_q <= fcnt_q + FCNT_W'(1);
      end else if (pop && !push) begin
        fcnt_q <= fcnt_q - FCNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fill_le_win : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= win_q)
    else $error("fill count exceeds window length");

  a_one_oldest : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full) |-> $onehot(del_vec))
    else $error("full window must have exactly one oldest entry");

  a_one_rank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $onehot(rank_vec))
    else $error("median rank must select exactly one cell");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && !pop && (fcnt_q == FCNT_W'(FIFO_DEPTH))))
    else $error("result queue overflow");

  a_result_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> out_valid_o)
    else $error("queued result not presented");

endmodule

`default_nettype wire
